// ===== rtl/skp_pkg.sv =====
// Shared types and constants for the skyline rectangle packer.
// No dependencies; imported by skp_cell and skyline_rectangle_packer.
package skp_pkg;

    localparam int SIDE_W = 14;
    localparam int END_W  = SIDE_W + 1;
    localparam int POS_W  = 13;
    localparam int CNT_W  = 11;

    localparam logic [SIDE_W-1:0] RESET_SIDE = SIDE_W'(1024);

    typedef enum logic [1:0] {
        ST_PLACED,
        ST_NOROOM,
        ST_FULL,
        ST_RESTART
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SWEEP,
        OP_UPDATE,
        OP_INSERT,
        OP_COMPACT,
        OP_RESTART
    } t_op;

    typedef struct packed {
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] lv;
        logic [SIDE_W-1:0] sp;
    } t_seg;

    typedef struct packed {
        logic v;
        t_seg seg;
    } t_trv;

    typedef struct packed {
        logic              found;
        logic [SIDE_W-1:0] y;
        logic [SIDE_W-1:0] x;
        logic [CNT_W-1:0]  idx;
        logic [CNT_W-1:0]  nfull;
        logic              rv;
        logic [SIDE_W-1:0] rlv;
        logic [SIDE_W-1:0] rsp;
        logic              ml;
        logic [SIDE_W-1:0] lx;
        logic [SIDE_W-1:0] lsp;
    } t_tok;

    typedef struct packed {
        t_op               op;
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [SIDE_W-1:0] aw;
        logic [SIDE_W-1:0] ah;
        logic [SIDE_W-1:0] rmax;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  b;
        logic [CNT_W-1:0]  host;
        logic [CNT_W-1:0]  start;
        t_seg              nseg;
        logic [END_W-1:0]  end_x;
    } t_ctl;

endpackage

// ===== rtl/skp_cell.sv =====
// One skyline cell: holds one segment, evaluates itself as a placement
// start while segment data streams in from the right. Uses skp_pkg.
module skp_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  skp_pkg::t_ctl i_ctl,
    input  skp_pkg::t_seg i_lseg,
    input  skp_pkg::t_seg i_rseg,
    input  skp_pkg::t_trv i_rtrv,
    input  skp_pkg::t_tok i_rtok,
    output skp_pkg::t_seg o_seg,
    output skp_pkg::t_trv o_trv,
    output skp_pkg::t_tok o_tok
);
    import skp_pkg::*;

    localparam logic [CNT_W-1:0] K = CNT_W'(CELL_IDX);
    localparam bit HAS_LEFT = (CELL_IDX > 0);

    t_seg              r_seg;
    t_trv              r_trv;
    t_tok              r_tok;
    logic              r_done;
    logic [SIDE_W-1:0] r_ymax;
    logic [CNT_W-1:0]  r_nfull;
    logic              r_rv;
    logic [SIDE_W-1:0] r_rlv;
    logic [SIDE_W-1:0] r_rsp;

    logic [END_W-1:0] own_end;
    logic [END_W-1:0] top_y;
    logic [END_W-1:0] trv_end;
    logic             covered;
    logic             full;
    logic             fit;
    logic             better;
    t_tok             cand;
    t_seg             own_trim;
    t_seg             left_trim;

    always_comb begin
        own_end = {1'b0, r_seg.x} + {1'b0, i_ctl.w};
        top_y   = {1'b0, r_ymax} + {1'b0, i_ctl.h};
        trv_end = {1'b0, r_trv.seg.x} + {1'b0, r_trv.seg.sp};
        covered = {1'b0, r_trv.seg.x} < own_end;
        full    = trv_end <= own_end;
        fit     = (K < i_ctl.cnt) && (own_end <= {1'b0, i_ctl.aw})
                  && (own_end <= {1'b0, i_ctl.rmax}) && (top_y <= {1'b0, i_ctl.ah});

        cand.found = fit;
        cand.y     = r_ymax;
        cand.x     = r_seg.x;
        cand.idx   = K;
        cand.nfull = r_nfull;
        cand.rv    = r_rv;
        cand.rlv   = r_rlv;
        cand.rsp   = r_rsp;
        cand.ml    = HAS_LEFT && ({1'b0, i_lseg.lv} == top_y);
        cand.lx    = i_lseg.x;
        cand.lsp   = i_lseg.sp;

        better = fit && (!i_rtok.found || (r_ymax < i_rtok.y)
                 || ((r_ymax == i_rtok.y) && (r_seg.x < i_rtok.x)));

        own_trim.x  = i_ctl.end_x[SIDE_W-1:0];
        own_trim.lv = r_seg.lv;
        own_trim.sp = SIDE_W'({1'b0, r_seg.x} + {1'b0, r_seg.sp} - i_ctl.end_x);

        left_trim = i_lseg;
        if ({1'b0, i_lseg.x} < i_ctl.end_x) begin
            left_trim.x  = i_ctl.end_x[SIDE_W-1:0];
            left_trim.sp = SIDE_W'({1'b0, i_lseg.x} + {1'b0, i_lseg.sp} - i_ctl.end_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            if (CELL_IDX == 0) begin
                r_seg <= '{x: '0, lv: '0, sp: RESET_SIDE};
            end
        end else begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_trv   <= '{v: (K < i_ctl.cnt), seg: r_seg};
                    r_done  <= 1'b0;
                    r_ymax  <= '0;
                    r_nfull <= '0;
                    r_rv    <= 1'b0;
                end
                OP_SWEEP: begin
                    r_trv <= i_rtrv;
                    r_tok <= better ? cand : i_rtok;
                    if (!r_done) begin
                        if (!r_trv.v) begin
                            r_done <= 1'b1;
                            r_rv   <= 1'b0;
                        end else begin
                            if (covered && (r_trv.seg.lv > r_ymax)) begin
                                r_ymax <= r_trv.seg.lv;
                            end
                            if (full) begin
                                r_nfull <= r_nfull + 1'b1;
                            end else begin
                                r_done <= 1'b1;
                                r_rv   <= 1'b1;
                                r_rlv  <= r_trv.seg.lv;
                                r_rsp  <= r_trv.seg.sp;
                            end
                        end
                    end
                end
                OP_UPDATE: begin
                    if (K == i_ctl.host) begin
                        r_seg <= i_ctl.nseg;
                    end else if ((K > i_ctl.host) && ({1'b0, r_seg.x} < i_ctl.end_x)) begin
                        r_seg <= own_trim;
                    end
                end
                OP_INSERT: begin
                    if (K == i_ctl.b) begin
                        r_seg <= i_ctl.nseg;
                    end else if (K > i_ctl.b) begin
                        r_seg <= left_trim;
                    end
                end
                OP_COMPACT: begin
                    if (K >= i_ctl.start) begin
                        r_seg <= i_rseg;
                    end
                end
                OP_RESTART: begin
                    if (CELL_IDX == 0) begin
                        r_seg <= '{x: '0, lv: '0, sp: i_ctl.aw};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_seg = r_seg;
    assign o_trv = r_trv;
    assign o_tok = r_tok;

endmodule

// ===== rtl/skyline_rectangle_packer.sv =====
// Top level of the skyline rectangle packer: control sequencer, atlas
// registers, result register and the row of skp_cell. Uses skp_pkg.
//
// The skyline lives in a row of MAX_SEGMENTS cells, one segment each. Segment
// data streams once through the row so every cell scores itself as a start,
// and the best start travels back to cell 0 in the same pass. A placed insert
// runs from the transfer through a load step, the sweep, a decide step, a
// step that rewrites the row, one shift per segment that the new rectangle
// removes to close the gap, and a hand-off that loads the result register.
// An insert that finds no room or a full table goes to the hand-off after
// the decide step, while a restart and a rectangle with a zero side skip the
// sweep. The next transfer is taken on the cycle after the result is loaded,
// while that result may still wait at the output; a second result then holds
// the input until the first is taken.
module skyline_rectangle_packer #(
    parameter int MAX_SEGMENTS   = 64,
    parameter int MAX_ATLAS_SIDE = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [13:0] i_rect_width,
    input  logic [13:0] i_rect_height,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [12:0] o_pos_x,
    output logic [12:0] o_pos_y
);
    import skp_pkg::*;

    localparam logic [END_W-1:0] SIDE_MAX = END_W'(MAX_ATLAS_SIDE);
    localparam logic [CNT_W-1:0] SEG_MAX  = CNT_W'(MAX_SEGMENTS);
    localparam logic             CFG_WIDTH  = 1'b0;
    localparam logic             CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESTART,
        S_LOAD,
        S_SWEEP,
        S_DECIDE,
        S_UPDATE,
        S_COMPACT,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [SIDE_W-1:0] r_aw;
    logic [SIDE_W-1:0] r_ah;
    logic [SIDE_W-1:0] r_rmax;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_t;
    logic [CNT_W-1:0]  r_d;
    logic [SIDE_W-1:0] r_w;
    logic [SIDE_W-1:0] r_h;
    logic              r_ins;
    logic [CNT_W-1:0]  r_b;
    logic [CNT_W-1:0]  r_host;
    logic [CNT_W-1:0]  r_start;
    t_seg              r_nseg;
    logic [END_W-1:0]  r_end;
    t_status           r_res_status;
    logic [POS_W-1:0]  r_res_x;
    logic [POS_W-1:0]  r_res_y;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [POS_W-1:0]  r_out_x;
    logic [POS_W-1:0]  r_out_y;

    logic [SIDE_W-1:0] aw_eff;
    logic [SIDE_W-1:0] ah_eff;
    logic              in_acc;
    t_ctl              ctl;
    t_tok              tok0;
    logic [SIDE_W-1:0] n_lv;
    logic              n_absorb;
    logic              n_ins;
    logic [CNT_W-1:0]  n_r;
    logic [CNT_W-1:0]  n_host;
    logic [CNT_W-1:0]  n_start;
    logic [SIDE_W-1:0] n_sp;

    t_seg w_seg [MAX_SEGMENTS];
    t_trv w_trv [MAX_SEGMENTS];
    t_tok w_tok [MAX_SEGMENTS];

    assign aw_eff = ({1'b0, r_aw} > SIDE_MAX) ? SIDE_MAX[SIDE_W-1:0] : r_aw;
    assign ah_eff = ({1'b0, r_ah} > SIDE_MAX) ? SIDE_MAX[SIDE_W-1:0] : r_ah;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign tok0 = w_tok[0];

    always_comb begin
        n_lv     = tok0.y + r_h;
        n_absorb = tok0.rv && (tok0.rlv == n_lv);
        n_ins    = (tok0.nfull == '0) && !tok0.ml;
        n_r      = tok0.idx + tok0.nfull;
        n_host   = n_absorb ? n_r : n_r - 1'b1;
        n_start  = tok0.ml ? tok0.idx - 1'b1 : tok0.idx;
        n_sp     = (tok0.ml ? tok0.lsp : '0) + r_w + (n_absorb ? tok0.rsp : '0);
    end

    always_comb begin
        ctl.w     = r_w;
        ctl.h     = r_h;
        ctl.aw    = aw_eff;
        ctl.ah    = ah_eff;
        ctl.rmax  = r_rmax;
        ctl.cnt   = r_cnt;
        ctl.b     = r_b;
        ctl.host  = r_host;
        ctl.start = r_start;
        ctl.nseg  = r_nseg;
        ctl.end_x = r_end;
        case (r_state)
            S_RESTART: ctl.op = OP_RESTART;
            S_LOAD:    ctl.op = OP_LOAD;
            S_SWEEP:   ctl.op = OP_SWEEP;
            S_UPDATE:  ctl.op = r_ins ? OP_INSERT : OP_UPDATE;
            S_COMPACT: ctl.op = OP_COMPACT;
            default:   ctl.op = OP_HOLD;
        endcase
    end

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        t_seg lseg;
        t_seg rseg;
        t_trv rtrv;
        t_tok rtok;
        if (g == 0) begin : g_first
            assign lseg = '0;
        end else begin : g_mid
            assign lseg = w_seg[g-1];
        end
        if (g == MAX_SEGMENTS - 1) begin : g_last
            assign rseg = w_seg[g];
            assign rtrv = '0;
            assign rtok = '0;
        end else begin : g_inner
            assign rseg = w_seg[g+1];
            assign rtrv = w_trv[g+1];
            assign rtok = w_tok[g+1];
        end
        skp_cell #(.CELL_IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_lseg  (lseg),
            .i_rseg  (rseg),
            .i_rtrv  (rtrv),
            .i_rtok  (rtok),
            .o_seg   (w_seg[g]),
            .o_trv   (w_trv[g]),
            .o_tok   (w_tok[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_aw        <= RESET_SIDE;
            r_ah        <= RESET_SIDE;
            r_rmax      <= RESET_SIDE;
            r_cnt       <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_aw <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEIGHT) begin
                    r_ah <= i_cfg_data;
                end
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_w     <= i_rect_width;
                        r_h     <= i_rect_height;
                        r_res_x <= '0;
                        r_res_y <= '0;
                        if (i_func) begin
                            r_state <= S_RESTART;
                        end else if (i_rect_width == '0 || i_rect_height == '0) begin
                            r_res_status <= ST_NOROOM;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_RESTART: begin
                    r_cnt        <= CNT_W'(1);
                    r_rmax       <= aw_eff;
                    r_res_status <= ST_RESTART;
                    r_state      <= S_DONE;
                end
                S_LOAD: begin
                    r_t     <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    r_t <= r_t + 1'b1;
                    if (r_t == SEG_MAX) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_ins   <= n_ins;
                    r_b     <= tok0.idx;
                    r_host  <= n_host;
                    r_start <= n_start;
                    r_d     <= n_host - n_start;
                    r_end   <= {1'b0, tok0.x} + {1'b0, r_w};
                    r_nseg  <= '{x: (tok0.ml ? tok0.lx : tok0.x), lv: n_lv, sp: n_sp};
                    if (!tok0.found) begin
                        r_res_status <= ST_NOROOM;
                        r_state      <= S_DONE;
                    end else if (n_ins && (r_cnt == SEG_MAX)) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_res_status <= ST_PLACED;
                        r_res_x      <= tok0.x[POS_W-1:0];
                        r_res_y      <= tok0.y[POS_W-1:0];
                        r_state      <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_ins) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_DONE;
                    end else if (r_d == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_COMPACT;
                    end
                end
                S_COMPACT: begin
                    r_cnt <= r_cnt - 1'b1;
                    r_d   <= r_d - 1'b1;
                    if (r_d == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_x      <= r_res_x;
                        r_out_y      <= r_res_y;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= SEG_MAX))
        else $error("segment count out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("transfer accepted but sequencer stayed idle");

    a_compact_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT) |-> (r_d != '0))
        else $error("compaction with nothing left to remove");

endmodule
